>>> hdl/fts_pkg.sv
// Shared types and constants of the flight time route splitter.
// Depends on nothing; every other file of the block uses it.
package fts_pkg;

  localparam int NODE_COUNT = 64;
  localparam int NODE_BITS  = $clog2(NODE_COUNT);
  localparam int PAIR_BITS  = 2 * NODE_BITS;
  localparam int DIST_BITS  = 16;
  localparam int TIME_W     = 24;
  localparam int SUM_W      = 32;
  localparam int FLT_W      = 10;
  localparam int MID_W      = 10;
  localparam int CMD_W      = 2;
  localparam int OWN_W      = DIST_BITS + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_NODE_LOAD = 2'd0,
    CMD_BASE_LOAD = 2'd1,
    CMD_MISSION   = 2'd2
  } cmd_t;

  // One accepted input item, as seen by the table stage.
  typedef struct packed {
    logic [CMD_W-1:0]     command;
    logic [NODE_BITS-1:0] from_node;
    logic [NODE_BITS-1:0] to_node;
    logic [DIST_BITS-1:0] distance_value;
    logic [MID_W-1:0]     mission_id;
    logic                 last_mission;
  } in_item_t;

  // Pipeline control from the top level.
  typedef struct packed {
    logic node_wr;
    logic base_wr;
    logic mission_acc;
    logic rd_en;
    logic upd_en;
  } pipe_ctl_t;

  // Registered table read data and sideband of the mission in the read stage.
  typedef struct packed {
    logic [MID_W-1:0]     mission_id;
    logic                 last_mission;
    logic [DIST_BITS-1:0] base_pick;
    logic [DIST_BITS-1:0] base_drop;
    logic [DIST_BITS-1:0] node_leg;
    logic [DIST_BITS-1:0] node_hop;
  } rd_data_t;

  // Rewrite of the return leg when the base distance of the last drop is reloaded.
  typedef struct packed {
    logic                 en;
    logic [DIST_BITS-1:0] value;
  } back_fix_t;

  // Result of the update stage, before the total is formed.
  typedef struct packed {
    logic [MID_W-1:0]  mission_id;
    logic [FLT_W-1:0]  flight_number;
    logic              starts_flight;
    logic [TIME_W-1:0] closed_time;
    logic [TIME_W-1:0] current_time;
    logic [SUM_W-1:0]  closed_sum;
    logic              last_mission;
  } upd_res_t;

  typedef struct packed {
    logic started;
  } upd_status_t;

endpackage

>>> hdl/fts_if.sv
// Channel interfaces of the flight time route splitter: input, result, config.
// Depends on fts_pkg for the field widths.
interface fts_in_if;
  logic                         valid;
  logic                         ready;
  logic [fts_pkg::CMD_W-1:0]     command;
  logic [fts_pkg::NODE_BITS-1:0] from_node;
  logic [fts_pkg::NODE_BITS-1:0] to_node;
  logic [fts_pkg::DIST_BITS-1:0] distance_value;
  logic [fts_pkg::MID_W-1:0]     mission_id;
  logic                         last_mission;

  modport source (output valid, command, from_node, to_node, distance_value,
                  mission_id, last_mission, input ready);
  modport sink (input valid, command, from_node, to_node, distance_value,
                mission_id, last_mission, output ready);
endinterface

interface fts_out_if;
  logic                      valid;
  logic                      ready;
  logic [fts_pkg::MID_W-1:0]  echoed_mission;
  logic [fts_pkg::FLT_W-1:0]  flight_number;
  logic                      starts_flight;
  logic [fts_pkg::TIME_W-1:0] closed_flight_time;
  logic [fts_pkg::TIME_W-1:0] current_flight_time;
  logic [fts_pkg::SUM_W-1:0]  total_time;
  logic                      sequence_done;

  modport source (output valid, echoed_mission, flight_number, starts_flight,
                  closed_flight_time, current_flight_time, total_time,
                  sequence_done, input ready);
  modport sink (input valid, echoed_mission, flight_number, starts_flight,
                closed_flight_time, current_flight_time, total_time,
                sequence_done, output ready);
endinterface

interface fts_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [fts_pkg::TIME_W-1:0] max_flight_time;

  modport source (output valid, max_flight_time, input ready);
  modport sink (input valid, max_flight_time, output ready);
endinterface

>>> hdl/fts_tables.sv
// Distance tables: node-to-node and node-to-base memories with registered reads.
// Depends on fts_pkg.
module fts_tables (
  input  logic               clk,
  input  logic               rst_n,
  input  fts_pkg::pipe_ctl_t  ctl,
  input  fts_pkg::in_item_t   item,
  output fts_pkg::rd_data_t   rd,
  output fts_pkg::back_fix_t  back_fix
);
  import fts_pkg::*;

  logic [DIST_BITS-1:0] node_mem [NODE_COUNT*NODE_COUNT];
  logic [DIST_BITS-1:0] base_mem [NODE_COUNT];
  logic [NODE_BITS-1:0] prev_drop_r;
  logic [NODE_BITS-1:0] prev_drop_nxt;
  rd_data_t             rd_r;

  always_ff @(posedge clk) begin
    if (ctl.node_wr) begin
      node_mem[{item.from_node, item.to_node}] <= item.distance_value;
    end
    if (ctl.base_wr) begin
      base_mem[item.from_node] <= item.distance_value;
    end
    if (ctl.rd_en) begin
      rd_r.node_leg     <= node_mem[{item.from_node, item.to_node}];
      rd_r.node_hop     <= node_mem[{prev_drop_r, item.from_node}];
      rd_r.base_pick    <= base_mem[item.from_node];
      rd_r.base_drop    <= base_mem[item.to_node];
      rd_r.mission_id   <= item.mission_id;
      rd_r.last_mission <= item.last_mission;
    end
  end

  // Delivery node of the previous mission, the start of the next hop.
  always_comb begin
    prev_drop_nxt = prev_drop_r;
    if (ctl.mission_acc) begin
      prev_drop_nxt = item.last_mission ? '0 : item.to_node;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_drop_r <= '0;
    end else begin
      prev_drop_r <= prev_drop_nxt;
    end
  end

  assign back_fix.en    = ctl.base_wr && (item.from_node == prev_drop_r);
  assign back_fix.value = item.distance_value;
  assign rd             = rd_r;

endmodule

>>> hdl/fts_update.sv
// Flight update stage: running flight time, closed sum and flight counter.
// Depends on fts_pkg.
module fts_update (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       upd_en,
  input  logic [fts_pkg::TIME_W-1:0] max_time,
  input  fts_pkg::rd_data_t          rd,
  input  fts_pkg::back_fix_t         back_fix,
  output fts_pkg::upd_res_t          res,
  output fts_pkg::upd_status_t       status
);
  import fts_pkg::*;

  logic [TIME_W-1:0]    acc_r, acc_nxt;
  logic [SUM_W-1:0]     sum_r, sum_nxt;
  logic [FLT_W-1:0]     cnt_r, cnt_nxt;
  logic                 started_r, started_nxt;
  logic [DIST_BITS-1:0] back_r, back_nxt;
  upd_res_t             res_r, res_nxt;

  logic [TIME_W-1:0]    back_ext;
  logic [TIME_W-1:0]    trimmed;
  logic [TIME_W:0]      grown;
  logic [TIME_W-1:0]    grown_sat;
  logic [OWN_W-1:0]     own;
  logic [SUM_W:0]       sum_raw;
  logic [SUM_W-1:0]     sum_sat;

  always_comb begin
    back_ext  = TIME_W'(back_r);
    trimmed   = (acc_r >= back_ext) ? (acc_r - back_ext) : '0;
    grown     = (TIME_W+1)'(trimmed) + (TIME_W+1)'(rd.node_hop)
              + (TIME_W+1)'(rd.node_leg) + (TIME_W+1)'(rd.base_drop);
    grown_sat = grown[TIME_W] ? '1 : grown[TIME_W-1:0];
    own       = OWN_W'(rd.base_pick) + OWN_W'(rd.node_leg) + OWN_W'(rd.base_drop);
    sum_raw   = (SUM_W+1)'(sum_r) + (SUM_W+1)'(acc_r);
    sum_sat   = sum_raw[SUM_W] ? '1 : sum_raw[SUM_W-1:0];
  end

  always_comb begin
    acc_nxt     = acc_r;
    sum_nxt     = sum_r;
    cnt_nxt     = cnt_r;
    started_nxt = started_r;
    back_nxt    = back_r;
    res_nxt     = res_r;
    if (upd_en) begin
      res_nxt.closed_time   = '0;
      res_nxt.starts_flight = 1'b1;
      if (!started_r) begin
        acc_nxt = TIME_W'(own);
        cnt_nxt = '0;
      end else if (grown_sat <= max_time) begin
        acc_nxt               = grown_sat;
        res_nxt.starts_flight = 1'b0;
      end else begin
        res_nxt.closed_time = acc_r;
        sum_nxt             = sum_sat;
        cnt_nxt             = cnt_r + FLT_W'(1);
        acc_nxt             = TIME_W'(own);
      end
      res_nxt.mission_id    = rd.mission_id;
      res_nxt.flight_number = cnt_nxt;
      res_nxt.current_time  = acc_nxt;
      res_nxt.closed_sum    = sum_nxt;
      res_nxt.last_mission  = rd.last_mission;
      started_nxt           = 1'b1;
      back_nxt              = rd.base_drop;
      if (rd.last_mission) begin
        acc_nxt     = '0;
        sum_nxt     = '0;
        cnt_nxt     = '0;
        started_nxt = 1'b0;
      end
    end
    // A base load accepted at this edge is younger than the mission above.
    if (back_fix.en) begin
      back_nxt = back_fix.value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r     <= '0;
      sum_r     <= '0;
      cnt_r     <= '0;
      started_r <= 1'b0;
    end else begin
      acc_r     <= acc_nxt;
      sum_r     <= sum_nxt;
      cnt_r     <= cnt_nxt;
      started_r <= started_nxt;
    end
  end

  always_ff @(posedge clk) begin
    back_r <= back_nxt;
    res_r  <= res_nxt;
  end

  assign res            = res_r;
  assign status.started = started_r;

endmodule

>>> hdl/flight_time_route_splitter_core.sv
// Flight time route splitter: greedy packing of missions into flights.
// A mission's result reaches the output channel through the table read, the flight
// update and the output register. Throughput: one item per cycle, loads and missions
// alike, while the output is not stalled; the update loop closes in its own registers.
// Reset (rst_n, synchronous, active low) clears the pipeline and the sequence state
// and sets max_flight_time to all ones; the distance tables hold nothing until loaded.
module flight_time_route_splitter_core (
  input logic  clk,
  input logic  rst_n,
  fts_in_if.sink    in_ch,
  fts_out_if.source out_ch,
  fts_cfg_if.sink   cfg_ch
);
  import fts_pkg::*;

  // The pipeline has three stages, each with its own valid flag. A stage takes
  // a new item whenever it is empty or its content moves on, so bubbles close
  // up and the input keeps taking transfers while a result waits at the output,
  // until the stages behind it are full.
  logic              s1_v_r, s2_v_r, out_v_r;
  logic              out_adv, s2_adv, s1_adv;
  logic              in_acc;
  logic [TIME_W-1:0] max_time_r;
  pipe_ctl_t         ctl;
  in_item_t          item;
  rd_data_t          rd;
  back_fix_t         back_fix;
  upd_res_t          res;
  upd_status_t       status;
  logic [SUM_W:0]    total_raw;
  logic [SUM_W-1:0]  total_sat;

  // Output payload registers.
  logic [MID_W-1:0]  out_mid_r;
  logic [FLT_W-1:0]  out_flt_r;
  logic              out_starts_r;
  logic [TIME_W-1:0] out_closed_r;
  logic [TIME_W-1:0] out_current_r;
  logic [SUM_W-1:0]  out_total_r;
  logic              out_done_r;

  assign out_adv = !out_v_r || out_ch.ready;
  assign s2_adv  = !s2_v_r || out_adv;
  assign s1_adv  = !s1_v_r || s2_adv;

  assign in_ch.ready = s1_adv;
  assign in_acc      = in_ch.valid && s1_adv;

  assign item.command        = in_ch.command;
  assign item.from_node      = in_ch.from_node;
  assign item.to_node        = in_ch.to_node;
  assign item.distance_value = in_ch.distance_value;
  assign item.mission_id     = in_ch.mission_id;
  assign item.last_mission   = in_ch.last_mission;

  // Only missions enter the pipeline; loads are written at their transfer and
  // the unused command code is dropped.
  assign ctl.node_wr     = in_acc && (in_ch.command == CMD_NODE_LOAD);
  assign ctl.base_wr     = in_acc && (in_ch.command == CMD_BASE_LOAD);
  assign ctl.mission_acc = in_acc && (in_ch.command == CMD_MISSION);
  assign ctl.rd_en       = s1_adv;
  assign ctl.upd_en      = s1_v_r && s2_adv;

  // The configuration register is always ready; the user must write only while idle; the block does not enforce it.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_time_r <= '1;
    end else if (cfg_ch.valid) begin
      max_time_r <= cfg_ch.max_flight_time;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (s1_adv) begin
        s1_v_r <= ctl.mission_acc;
      end
      if (s2_adv) begin
        s2_v_r <= s1_v_r;
      end
      if (out_adv) begin
        out_v_r <= s2_v_r;
      end
    end
  end

  fts_tables u_tables (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (ctl),
    .item     (item),
    .rd       (rd),
    .back_fix (back_fix)
  );

  fts_update u_update (
    .clk      (clk),
    .rst_n    (rst_n),
    .upd_en   (ctl.upd_en),
    .max_time (max_time_r),
    .rd       (rd),
    .back_fix (back_fix),
    .res      (res),
    .status   (status)
  );

  // The total is formed in the output stage from the closed sum and the running
  // time the update stage left, so it stays off the update loop.
  always_comb begin
    total_raw = (SUM_W+1)'(res.closed_sum) + (SUM_W+1)'(res.current_time);
    total_sat = total_raw[SUM_W] ? '1 : total_raw[SUM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (s2_v_r && out_adv) begin
      out_mid_r     <= res.mission_id;
      out_flt_r     <= res.flight_number;
      out_starts_r  <= res.starts_flight;
      out_closed_r  <= res.closed_time;
      out_current_r <= res.current_time;
      out_total_r   <= res.last_mission ? total_sat : '0;
      out_done_r    <= res.last_mission;
    end
  end

  assign out_ch.valid               = out_v_r;
  assign out_ch.echoed_mission      = out_mid_r;
  assign out_ch.flight_number       = out_flt_r;
  assign out_ch.starts_flight       = out_starts_r;
  assign out_ch.closed_flight_time  = out_closed_r;
  assign out_ch.current_flight_time = out_current_r;
  assign out_ch.total_time          = out_total_r;
  assign out_ch.sequence_done       = out_done_r;

  // The last mission of a sequence leaves the sequence state closed.
  a_seq_closes: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.upd_en && rd.last_mission) |=> !status.started)
    else $error("sequence still open after its last mission");

  // A mission that joins the open flight closes nothing.
  a_no_close: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_starts_r) |-> (out_closed_r == '0))
    else $error("closed time reported without a new flight");

  // The total is only given with the last mission.
  a_total_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_v_r && !out_done_r) |-> (out_total_r == '0))
    else $error("total time reported before the end of the sequence");

endmodule

>>> sim/flight_time_route_splitter_core_tb.sv
// Self-checking testbench for flight_time_route_splitter_core: directed rows, then
// random load and mission traffic, checked against an in-bench flight planner.
// Depends on fts_pkg, the fts channel interfaces and the core itself.
`timescale 1ns / 100ps

module flight_time_route_splitter_core_tb;
  import fts_pkg::*;

  // Command code 3 has no package name, since the core simply drops it.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

  localparam int DIRECTED_ROWS = 19;
  localparam int SETTLE_CYCLES = 8;
  localparam int DRAIN_CYCLES  = 10;
  localparam int CYCLE_LIMIT   = 500000;
  localparam int REPORT_LIMIT  = 10;

  // One expected or observed mission result.
  typedef struct packed {
    logic [MID_W-1:0]  mission;
    logic [FLT_W-1:0]  flight;
    logic              starts;
    logic [TIME_W-1:0] closed;
    logic [TIME_W-1:0] current;
    logic [SUM_W-1:0]  total;
    logic              done;
  } flight_res_t;

  typedef enum logic {ROW_ITEM, ROW_LIMIT} row_kind_t;

  // A row of the directed table: an input item or a limit write, and where the
  // outcome is obvious from the arithmetic, the result typed in by hand.
  typedef struct packed {
    row_kind_t         kind;
    in_item_t          item;
    logic [TIME_W-1:0] limit;
    logic              typed;
    flight_res_t       want;
  } plan_row_t;

  logic clk = 1'b0;
  logic rst_n;

  fts_in_if  in_ch();
  fts_out_if out_ch();
  fts_cfg_if cfg_ch();

  flight_time_route_splitter_core dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // -------------------------------------------------------------------------
  // Flight planner state. It mirrors what the core must hold: both distance
  // tables, the open flight, the sum of closed flights and the flight counter.
  // -------------------------------------------------------------------------
  logic [DIST_BITS-1:0] dist_grid [NODE_COUNT*NODE_COUNT];
  logic [DIST_BITS-1:0] base_leg  [NODE_COUNT];
  logic [TIME_W-1:0]    open_time;
  logic [NODE_BITS-1:0] last_drop;
  logic [SUM_W-1:0]     closed_total;
  logic [FLT_W-1:0]     flight_idx;
  logic                 seq_open;
  logic [TIME_W-1:0]    time_limit;

  // Which table entries the stimulus has written. Missions are only ever
  // generated once every entry they read has been loaded.
  bit grid_loaded [NODE_COUNT*NODE_COUNT];
  bit base_loaded [NODE_COUNT];

  flight_res_t       due_flights [$];
  int unsigned       bad_results;
  int unsigned       cycles;
  bit                gaps_on;
  int                stall_left;
  logic [NODE_BITS-1:0] hot_nodes [8];
  plan_row_t         directed_rows [DIRECTED_ROWS];
  flight_res_t       got;

  function automatic logic [TIME_W-1:0] clip_time(input longint unsigned v);
    return (v > 64'hFF_FFFF) ? 24'hFF_FFFF : v[TIME_W-1:0];
  endfunction

  function automatic logic [SUM_W-1:0] clip_sum(input longint unsigned v);
    return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[SUM_W-1:0];
  endfunction

  // Works out what one accepted item does to the planner and, for a mission,
  // queues the result the core has to produce. A hand-typed result replaces
  // the computed one where the directed table supplies it.
  task automatic assign_flight(input in_item_t it, input logic typed,
                               input flight_res_t want);
    longint unsigned own_time;
    longint unsigned run_time;
    longint unsigned back_leg;
    longint unsigned sum;
    flight_res_t     r;
    r = '0;
    case (it.command)
      CMD_NODE_LOAD: dist_grid[{it.from_node, it.to_node}] = it.distance_value;
      CMD_BASE_LOAD: base_leg[it.from_node] = it.distance_value;
      CMD_MISSION: begin
        // Base to pickup, pickup to delivery and delivery back to base.
        own_time = base_leg[it.from_node] + dist_grid[{it.from_node, it.to_node}]
                   + base_leg[it.to_node];
        if (!seq_open) begin
          open_time  = clip_time(own_time);
          flight_idx = '0;
          r.starts   = 1'b1;
          seq_open   = 1'b1;
        end else begin
          // Take off the return leg of the previous delivery (never below
          // zero), then add the hop, the mission leg and the new return leg.
          back_leg = base_leg[last_drop];
          run_time = open_time;
          run_time = (run_time >= back_leg) ? run_time - back_leg : 0;
          run_time = run_time + dist_grid[{last_drop, it.from_node}]
                     + dist_grid[{it.from_node, it.to_node}] + base_leg[it.to_node];
          run_time = clip_time(run_time);
          if (run_time <= time_limit) begin
            open_time = run_time[TIME_W-1:0];
          end else begin
            // The open flight closes and this mission opens the next one,
            // however long it is on its own.
            sum          = closed_total + open_time;
            r.closed     = open_time;
            closed_total = clip_sum(sum);
            flight_idx   = flight_idx + 1'b1;
            open_time    = clip_time(own_time);
            r.starts     = 1'b1;
          end
        end
        last_drop = it.to_node;
        if (it.last_mission) begin
          sum     = closed_total + open_time;
          r.total = clip_sum(sum);
        end
        r.mission = it.mission_id;
        r.flight  = flight_idx;
        r.current = open_time;
        r.done    = it.last_mission;
        if (typed) begin
          due_flights = {due_flights, want};
        end else begin
          due_flights = {due_flights, r};
        end
        // The tables survive the end of a sequence; nothing else does.
        if (it.last_mission) begin
          open_time    = '0;
          last_drop    = '0;
          closed_total = '0;
          flight_idx   = '0;
          seq_open     = 1'b0;
        end
      end
      default: ;
    endcase
  endtask

  function automatic in_item_t make_item(input logic [CMD_W-1:0] cmd,
                                         input logic [NODE_BITS-1:0] p,
                                         input logic [NODE_BITS-1:0] q,
                                         input logic [DIST_BITS-1:0] d,
                                         input logic [MID_W-1:0] mid,
                                         input logic last);
    in_item_t it;
    it.command        = cmd;
    it.from_node      = p;
    it.to_node        = q;
    it.distance_value = d;
    it.mission_id     = mid;
    it.last_mission   = last;
    return it;
  endfunction

  function automatic plan_row_t row_item(input logic [CMD_W-1:0] cmd,
                                         input logic [NODE_BITS-1:0] p,
                                         input logic [NODE_BITS-1:0] q,
                                         input logic [DIST_BITS-1:0] d,
                                         input logic [MID_W-1:0] mid,
                                         input logic last);
    plan_row_t row;
    row      = '0;
    row.kind = ROW_ITEM;
    row.item = make_item(cmd, p, q, d, mid, last);
    return row;
  endfunction

  function automatic plan_row_t row_limit(input logic [TIME_W-1:0] v);
    plan_row_t row;
    row       = '0;
    row.kind  = ROW_LIMIT;
    row.limit = v;
    return row;
  endfunction

  function automatic plan_row_t with_result(input plan_row_t row, input flight_res_t r);
    row.typed = 1'b1;
    row.want  = r;
    return row;
  endfunction

  // Distances lean towards modest values, with zero, all ones and fully
  // random words mixed in.
  function automatic logic [DIST_BITS-1:0] rand_dist();
    case ($urandom_range(0, 9))
      0:       return '0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom);
      default: return 16'($urandom_range(1, 3000));
    endcase
  endfunction

  // Mostly a node from the small working set of the phase, so that routes
  // revisit loaded entries; now and then any node at all.
  function automatic logic [NODE_BITS-1:0] pick_node();
    if ($urandom_range(0, 4) == 0) return 6'($urandom_range(0, NODE_COUNT - 1));
    return hot_nodes[$urandom_range(0, 7)];
  endfunction

  // Presents one item at a falling edge, holds it until the transfer and
  // then updates the planner. A random gap may come first. Entered and left
  // at a falling edge, so valid never gets two assignments in one step.
  task automatic send_item(input in_item_t it, input logic typed, input flight_res_t want);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
    if (it.command == CMD_NODE_LOAD) grid_loaded[{it.from_node, it.to_node}] = 1'b1;
    if (it.command == CMD_BASE_LOAD) base_loaded[it.from_node] = 1'b1;
    in_ch.valid          <= 1'b1;
    in_ch.command        <= it.command;
    in_ch.from_node      <= it.from_node;
    in_ch.to_node        <= it.to_node;
    in_ch.distance_value <= it.distance_value;
    in_ch.mission_id     <= it.mission_id;
    in_ch.last_mission   <= it.last_mission;
    do @(posedge clk); while (!in_ch.ready);
    assign_flight(it, typed, want);
    @(negedge clk);
  endtask

  task automatic need_base(input logic [NODE_BITS-1:0] n);
    if (!base_loaded[n])
      send_item(make_item(CMD_BASE_LOAD, n, 6'($urandom), rand_dist(), 10'($urandom),
                          1'($urandom)), 1'b0, '0);
  endtask

  task automatic need_grid(input logic [NODE_BITS-1:0] a, input logic [NODE_BITS-1:0] b);
    if (!grid_loaded[{a, b}])
      send_item(make_item(CMD_NODE_LOAD, a, b, rand_dist(), 10'($urandom), 1'($urandom)),
                1'b0, '0);
  endtask

  // Loads whatever a mission from p to q would read and is still unwritten:
  // the legs of the mission itself and the hop from the previous delivery.
  task automatic route_ready(input logic [NODE_BITS-1:0] p, input logic [NODE_BITS-1:0] q);
    need_base(last_drop);
    need_grid(last_drop, p);
    need_base(p);
    need_grid(p, q);
    need_base(q);
  endtask

  // The limit is only changed with the core idle: every result in and the
  // pipeline given time to finish any trailing load.
  task automatic write_limit(input logic [TIME_W-1:0] v);
    in_ch.valid <= 1'b0;
    while (due_flights.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    cfg_ch.valid           <= 1'b1;
    cfg_ch.max_flight_time <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    time_limit = v;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Random traffic under one flight limit: mostly well-formed missions over
  // a small working set, with reloads of either table (including the return
  // leg of the open flight) and the odd unused command mixed in.
  task automatic roam_phase(input logic [TIME_W-1:0] limit, input int count);
    int                   issued;
    int                   choice;
    logic [NODE_BITS-1:0] p;
    logic [NODE_BITS-1:0] q;
    issued = 0;
    write_limit(limit);
    gaps_on = ($urandom_range(0, 3) != 0);
    foreach (hot_nodes[k]) hot_nodes[k] = 6'($urandom_range(0, NODE_COUNT - 1));
    while (issued < count) begin
      choice = $urandom_range(0, 19);
      if (choice < 13) begin
        p = pick_node();
        q = pick_node();
        route_ready(p, q);
        send_item(make_item(CMD_MISSION, p, q, 16'($urandom), 10'($urandom),
                            $urandom_range(0, 9) == 0), 1'b0, '0);
      end else if (choice < 16) begin
        p = ($urandom_range(0, 2) == 0) ? last_drop : pick_node();
        send_item(make_item(CMD_BASE_LOAD, p, 6'($urandom), rand_dist(), 10'($urandom),
                            1'($urandom)), 1'b0, '0);
      end else if (choice < 19) begin
        send_item(make_item(CMD_NODE_LOAD, pick_node(), pick_node(), rand_dist(),
                            10'($urandom), 1'($urandom)), 1'b0, '0);
      end else begin
        send_item(make_item(CMD_UNUSED, 6'($urandom), 6'($urandom), 16'($urandom),
                            10'($urandom), 1'($urandom)), 1'b0, '0);
      end
      if (choice != 19) issued++;
    end
  endtask

  // One long sequence over nodes 60 to 63. With every distance nonzero and
  // a limit of zero each mission opens a flight of its own, so the flight
  // counter steps on every mission. With every distance at all ones and a
  // limit one below the top, the running time of the first flight reaches
  // saturation after about a hundred and thirty missions, which closes it.
  task automatic marathon(input logic [TIME_W-1:0] limit, input logic heavy,
                          input int count);
    logic [NODE_BITS-1:0] p;
    logic [NODE_BITS-1:0] q;
    write_limit(limit);
    for (int a = 60; a < NODE_COUNT; a++) begin
      send_item(make_item(CMD_BASE_LOAD, 6'(a), '0,
                          heavy ? 16'hFFFF : 16'($urandom_range(1, 4000)), '0, 1'b0),
                1'b0, '0);
      for (int b = 60; b < NODE_COUNT; b++)
        send_item(make_item(CMD_NODE_LOAD, 6'(a), 6'(b),
                            heavy ? 16'hFFFF : 16'($urandom_range(1, 4000)), '0, 1'b0),
                  1'b0, '0);
    end
    for (int k = 0; k < count; k++) begin
      p = 6'($urandom_range(60, NODE_COUNT - 1));
      q = 6'($urandom_range(60, NODE_COUNT - 1));
      route_ready(p, q);
      send_item(make_item(CMD_MISSION, p, q, 16'($urandom), 10'($urandom), k == count - 1),
                1'b0, '0);
    end
  endtask

  task automatic note_mismatch(input string what, input flight_res_t want,
                               input flight_res_t seen);
    bad_results++;
    if (bad_results <= REPORT_LIMIT)
      $display("%0t %s: expected mission %0d flight %0d start %0b closed %0d current %0d",
               $realtime, what, want.mission, want.flight, want.starts, want.closed,
               want.current, " total %0d done %0b; got mission %0d flight %0d start %0b",
               want.total, want.done, seen.mission, seen.flight, seen.starts,
               " closed %0d current %0d total %0d done %0b",
               seen.closed, seen.current, seen.total, seen.done);
  endtask

  // Result side: random bursts of stall while gaps are enabled.
  always @(negedge clk) begin
    if (stall_left == 0 && gaps_on && $urandom_range(0, 5) == 0)
      stall_left = $urandom_range(1, 14);
    if (stall_left > 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Every result transfer is matched against the oldest outstanding
  // expectation; anything arriving with nothing outstanding is an error.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.mission = out_ch.echoed_mission;
      got.flight  = out_ch.flight_number;
      got.starts  = out_ch.starts_flight;
      got.closed  = out_ch.closed_flight_time;
      got.current = out_ch.current_flight_time;
      got.total   = out_ch.total_time;
      got.done    = out_ch.sequence_done;
      if (due_flights.size() == 0) begin
        note_mismatch("unexpected result", '0, got);
      end else if (got !== due_flights[0]) begin
        note_mismatch("result mismatch", due_flights.pop_front(), got);
      end else begin
        void'(due_flights.pop_front());
      end
    end
  end

  // Watchdog: a run that stalls or loses results ends here.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("flight_time_route_splitter_core_tb NOT OK");
    $finish;
  end

  initial begin
    rst_n                  = 1'b0;
    in_ch.valid            = 1'b0;
    in_ch.command          = '0;
    in_ch.from_node        = '0;
    in_ch.to_node          = '0;
    in_ch.distance_value   = '0;
    in_ch.mission_id       = '0;
    in_ch.last_mission     = 1'b0;
    out_ch.ready           = 1'b0;
    cfg_ch.valid           = 1'b0;
    cfg_ch.max_flight_time = '0;
    bad_results            = 0;
    stall_left             = 0;
    gaps_on                = 1'b1;
    open_time              = '0;
    last_drop              = '0;
    closed_total           = '0;
    flight_idx             = '0;
    seq_open               = 1'b0;
    time_limit             = 24'hFF_FFFF;
    foreach (dist_grid[k]) dist_grid[k] = '0;
    foreach (base_leg[k]) base_leg[k] = '0;

    // The first block runs under the reset limit of all ones. Node 63 carries
    // the largest distances, so the second mission must still append. The
    // unused command must vanish without a result. After the limit drops to
    // zero, the base distance of the open flight's last delivery is reloaded
    // with a value larger than the flight so far, which clamps the running
    // time at zero before the new legs are added. The last block places the
    // limit exactly on the second mission's running time.
    directed_rows = '{
      row_item(CMD_BASE_LOAD, 6'd0, 6'd0, 16'd10, 10'd0, 1'b0),
      row_item(CMD_BASE_LOAD, 6'd63, 6'd0, 16'hFFFF, 10'd0, 1'b0),
      row_item(CMD_NODE_LOAD, 6'd0, 6'd63, 16'd5, 10'd0, 1'b0),
      row_item(CMD_NODE_LOAD, 6'd63, 6'd63, 16'hFFFF, 10'd0, 1'b0),
      row_item(CMD_NODE_LOAD, 6'd63, 6'd0, 16'd0, 10'd0, 1'b0),
      row_item(CMD_NODE_LOAD, 6'd0, 6'd0, 16'd3, 10'd0, 1'b0),
      with_result(row_item(CMD_MISSION, 6'd0, 6'd63, 16'd0, 10'd1023, 1'b0),
                  flight_res_t'{10'd1023, 10'd0, 1'b1, 24'd0, 24'd65550, 32'd0, 1'b0}),
      with_result(row_item(CMD_MISSION, 6'd63, 6'd63, 16'hFFFF, 10'd0, 1'b0),
                  flight_res_t'{10'd0, 10'd0, 1'b0, 24'd0, 24'd196620, 32'd0, 1'b0}),
      row_item(CMD_UNUSED, 6'd63, 6'd63, 16'hFFFF, 10'd1023, 1'b1),
      row_item(CMD_MISSION, 6'd0, 6'd0, 16'd0, 10'd512, 1'b1),
      row_limit(24'd0),
      row_item(CMD_MISSION, 6'd0, 6'd0, 16'd0, 10'd5, 1'b0),
      row_item(CMD_BASE_LOAD, 6'd0, 6'd0, 16'hFFFF, 10'd0, 1'b0),
      row_item(CMD_MISSION, 6'd0, 6'd0, 16'd0, 10'd6, 1'b0),
      row_item(CMD_MISSION, 6'd0, 6'd63, 16'd0, 10'd7, 1'b1),
      row_limit(24'd131079),
      row_item(CMD_MISSION, 6'd0, 6'd0, 16'd0, 10'd8, 1'b0),
      row_item(CMD_MISSION, 6'd0, 6'd0, 16'd0, 10'd9, 1'b0),
      row_item(CMD_MISSION, 6'd0, 6'd0, 16'd0, 10'd10, 1'b1)
    };

    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_LIMIT) begin
        write_limit(directed_rows[r].limit);
      end else begin
        send_item(directed_rows[r].item, directed_rows[r].typed, directed_rows[r].want);
      end
    end

    roam_phase(24'($urandom_range(2000, 12000)), 80);
    roam_phase(24'd0, 40);
    roam_phase(24'hFF_FFFF, 40);
    roam_phase(24'($urandom_range(500, 30000)), 80);

    // The closing stretch runs at full rate on both sides.
    gaps_on = 1'b0;
    marathon(24'd0, 1'b0, 60);
    marathon(24'hFF_FFFE, 1'b1, 150);

    in_ch.valid <= 1'b0;
    while (due_flights.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (bad_results == 0) begin
      $display("flight_time_route_splitter_core_tb OK");
    end else begin
      $display("flight_time_route_splitter_core_tb NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
hdl/fts_pkg.sv
hdl/fts_if.sv
hdl/fts_tables.sv
hdl/fts_update.sv
hdl/flight_time_route_splitter_core.sv
sim/flight_time_route_splitter_core_tb.sv
